### hw/rtl/rgbe_scanline_rle_decoder_macros.svh
// Assertion macros shared by the checker of the scanline decoder.
`ifndef RGBE_SCANLINE_RLE_DECODER_MACROS_SVH
`define RGBE_SCANLINE_RLE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsrd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsrd: next-cycle check failed");

`endif

### hw/rtl/rsrd_pkg.sv
package rsrd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = 16;
    localparam int RUN_BIAS   = 128;
    localparam int RESET_WIDTH  = 320;
    localparam int RESET_HEIGHT = 240;

    localparam logic [15:0] ROW_MARK = 16'h0202;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_HDR2   = 3'd2,
        PH_HDR3   = 3'd3,
        PH_CODE   = 3'd4,
        PH_RUNVAL = 3'd5,
        PH_LIT    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUT,
        ST_EXP,
        ST_CONV
    } state_t;

    typedef enum logic [1:0] {
        PL_RED   = 2'd0,
        PL_GREEN = 2'd1,
        PL_BLUE  = 2'd2,
        PL_EXP   = 2'd3
    } plane_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

### hw/rtl/rsrd_if.sv
interface rsrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_image;

    modport source (output valid, data_byte, start_of_image, input ready);
    modport sink   (input valid, data_byte, start_of_image, output ready);
endinterface

interface rsrd_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] pixel_row;
    logic [11:0] pixel_column;
    logic [31:0] red_first;
    logic [31:0] green_first;
    logic [31:0] blue_first;
    logic [31:0] red_second;
    logic [31:0] green_second;
    logic [31:0] blue_second;
    logic        second_valid;
    logic        last_of_run;

    modport source (output valid, pixel_row, pixel_column, red_first, green_first,
                    blue_first, red_second, green_second, blue_second, second_valid,
                    last_of_run, input ready);
    modport sink   (input valid, pixel_row, pixel_column, red_first, green_first,
                    blue_first, red_second, green_second, blue_second, second_valid,
                    last_of_run, output ready);
endinterface

### hw/rtl/rsrd_pix_cvt.sv
// Turn one RGBE pixel (three mantissas, shared exponent) into IEEE single bits.
module rsrd_pix_cvt (
    input  logic [23:0] mant,
    input  logic [7:0]  expo,
    output logic [31:0] red,
    output logic [31:0] green,
    output logic [31:0] blue
);

    function automatic logic [31:0] to_float(input logic [7:0] v, input logic [7:0] e);
        logic [2:0]  p;
        logic [9:0]  pe;
        logic [30:0] sh;
        logic [31:0] res;
        p = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                p = 3'(i);
            end
        end
        pe = {7'd0, p} + {2'd0, e};
        sh = {v, 23'd0} >> p;
        if (e == 8'd0 || v == 8'd0)
        begin
            res = 32'd0;
        end
        else if (pe >= 10'd10)
        begin
            res = {1'b0, 8'(pe - 10'd9), sh[22:0]};
        end
        else
        begin
            // subnormal: shift stays below 23
            res = {24'd0, v} << (e + 8'd13);
        end
        return res;
    endfunction

    assign red   = to_float(mant[7:0], expo);
    assign green = to_float(mant[15:8], expo);
    assign blue  = to_float(mant[23:16], expo);

endmodule

### hw/rtl/rgbe_scanline_rle_decoder.sv
// Channel  | Dir | Carries
// ---------+-----+-----------------------------------------------------------
// in_ch    | in  | one coded byte per request, start_of_image flag
// out_ch   | out | up to two IEEE-single RGB pixels per request, row/column
// apb      | in  | image_width at 0x0, image_height at 0x4
//
// A header, code or plane byte of the red/green/blue planes is accepted in
// idle; ST_PUT then writes one stored value per cycle to the line memory.
// An exponent byte walks the line memory up to two columns a step; a pair is
// read (ST_EXP), then converted (ST_CONV), and an output stall holds the walk.
// Output is a register: a new byte is taken while a result still waits.
// rst_n clears sequencer and config state asynchronously, not the line memory.
module rgbe_scanline_rle_decoder (
    input  logic        clk,
    input  logic        rst_n,
    rsrd_in_if.sink     in_ch,
    rsrd_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = rsrd_pkg::ADDR_W;

    // decode control
    rsrd_pkg::state_t st_reg, st_next;
    rsrd_pkg::phase_t ph_reg, ph_next;
    logic [1:0]  pl_reg, pl_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] lw_reg, lw_next;
    logic [14:0] row_reg, row_next;
    logic [7:0]  lit_reg, lit_next;
    logic [23:0] hdr_reg, hdr_next;
    logic [7:0]  left_reg, left_next;
    logic        litm_reg, litm_next;
    logic        more_reg, more_next;
    logic [7:0]  exp_reg, exp_next;
    logic [14:0] orow_reg, orow_next;
    logic [AW-1:0] pcol_reg, pcol_next;
    logic        has2_reg, has2_next;
    logic        last_reg, last_next;
    logic [12:0] wid_reg;
    logic [14:0] hgt_reg;

    // output register
    logic        ovalid_reg, ovalid_next;
    logic [14:0] orow_out_reg;
    logic [11:0] ocol_out_reg;
    logic [31:0] r1_reg, g1_reg, b1_reg, r2_reg, g2_reg, b2_reg;
    logic        sv_reg, lr_reg;
    logic        oload;

    // line memory: blue, green, red bytes of each column
    logic [23:0]   mem_q [rsrd_pkg::MAX_WIDTH];
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr0, raddr1;
    logic [23:0]   rd0_reg, rd1_reg;

    logic [31:0] cr1, cg1, cb1, cr2, cg2, cb2;
    logic        accept;
    logic        cfg_wr;

    assign accept    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (st_reg == rsrd_pkg::ST_IDLE);
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    always_comb
    begin
        case (rsrd_pkg::reg_idx_t'(paddr[2]))
            rsrd_pkg::REG_WIDTH:  prdata = {19'd0, wid_reg};
            rsrd_pkg::REG_HEIGHT: prdata = {17'd0, hgt_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_reg <= 13'(rsrd_pkg::RESET_WIDTH);
            hgt_reg <= 15'(rsrd_pkg::RESET_HEIGHT);
        end
        else if (cfg_wr)
        begin
            case (rsrd_pkg::reg_idx_t'(paddr[2]))
                rsrd_pkg::REG_WIDTH:  wid_reg <= pwdata[12:0];
                rsrd_pkg::REG_HEIGHT: hgt_reg <= pwdata[14:0];
                default:              wid_reg <= wid_reg;
            endcase
        end
    end

    // Main sequencer: header parsing, code decode and the per-column walk.
    always_comb
    begin
        logic [16:0] x1, x2, xk, lim;
        logic        emit0, take2, emit1, le, more;
        logic [7:0]  leftk;
        st_next   = st_reg;
        ph_next   = ph_reg;
        pl_next   = pl_reg;
        col_next  = col_reg;
        lw_next   = lw_reg;
        row_next  = row_reg;
        lit_next  = lit_reg;
        hdr_next  = hdr_reg;
        left_next = left_reg;
        litm_next = litm_reg;
        more_next = more_reg;
        exp_next  = exp_reg;
        orow_next = orow_reg;
        pcol_next = pcol_reg;
        has2_next = has2_reg;
        last_next = last_reg;
        we    = 1'b0;
        waddr = col_reg[AW-1:0];
        wdata = exp_reg;
        re    = 1'b0;
        raddr0 = col_reg[AW-1:0];
        raddr1 = AW'(col_reg + 16'd1);
        oload  = 1'b0;
        x1 = {1'b0, col_reg} + 17'd1;
        x2 = {1'b0, col_reg} + 17'd2;
        lim = (wid_reg < 13'(rsrd_pkg::MAX_WIDTH)) ? {4'd0, wid_reg}
                                                   : 17'(rsrd_pkg::MAX_WIDTH);
        emit0 = {1'b0, col_reg} < lim;
        take2 = (left_reg >= 8'd2) && (x1 < {1'b0, lw_reg});
        emit1 = take2 && (x1 < lim);
        xk    = take2 ? x2 : x1;
        leftk = take2 ? left_reg - 8'd2 : left_reg - 8'd1;
        le    = take2 ? (x2 >= {1'b0, lw_reg}) : (x1 >= {1'b0, lw_reg});
        more  = (leftk != 8'd0) && !le;

        case (st_reg)
            rsrd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.start_of_image)
                    begin
                        ph_next  = rsrd_pkg::PH_HDR0;
                        pl_next  = 2'd0;
                        col_next = 16'd0;
                        lw_next  = 16'd0;
                        row_next = 15'd0;
                        lit_next = 8'd0;
                        hdr_next = 24'd0;
                    end
                    if (row_next < hgt_reg)
                    begin
                        orow_next = row_next;
                        exp_next  = in_ch.data_byte;
                        case (ph_next)
                            rsrd_pkg::PH_HDR0, rsrd_pkg::PH_HDR1, rsrd_pkg::PH_HDR2:
                            begin
                                hdr_next = {hdr_next[15:0], in_ch.data_byte};
                                ph_next  = rsrd_pkg::phase_t'(ph_next + 3'd1);
                            end
                            rsrd_pkg::PH_HDR3:
                            begin
                                if (hdr_next[23:8] == rsrd_pkg::ROW_MARK &&
                                    {hdr_next[7:0], in_ch.data_byte} != 16'd0)
                                begin
                                    lw_next  = {hdr_next[7:0], in_ch.data_byte};
                                    pl_next  = 2'd0;
                                    col_next = 16'd0;
                                    lit_next = 8'd0;
                                    ph_next  = rsrd_pkg::PH_CODE;
                                end
                                else
                                begin
                                    if (hdr_next[23:8] == rsrd_pkg::ROW_MARK)
                                    begin
                                        lw_next = 16'd0;
                                    end
                                    row_next = row_next + 15'd1;
                                    ph_next  = rsrd_pkg::PH_HDR0;
                                    pl_next  = 2'd0;
                                    col_next = 16'd0;
                                    lit_next = 8'd0;
                                end
                                hdr_next = 24'd0;
                            end
                            rsrd_pkg::PH_CODE:
                            begin
                                if (in_ch.data_byte > 8'(rsrd_pkg::RUN_BIAS))
                                begin
                                    lit_next = in_ch.data_byte - 8'(rsrd_pkg::RUN_BIAS);
                                    ph_next  = rsrd_pkg::PH_RUNVAL;
                                end
                                else if (in_ch.data_byte != 8'd0)
                                begin
                                    lit_next = in_ch.data_byte;
                                    ph_next  = rsrd_pkg::PH_LIT;
                                end
                            end
                            rsrd_pkg::PH_RUNVAL:
                            begin
                                ph_next   = rsrd_pkg::PH_CODE;
                                left_next = lit_next;
                                lit_next  = 8'd0;
                                litm_next = 1'b0;
                                if (left_next != 8'd0)
                                begin
                                    st_next = (pl_next == 2'(rsrd_pkg::PL_EXP))
                                              ? rsrd_pkg::ST_EXP : rsrd_pkg::ST_PUT;
                                end
                            end
                            rsrd_pkg::PH_LIT:
                            begin
                                lit_next  = lit_next - 8'd1;
                                left_next = 8'd1;
                                litm_next = 1'b1;
                                st_next = (pl_next == 2'(rsrd_pkg::PL_EXP))
                                          ? rsrd_pkg::ST_EXP : rsrd_pkg::ST_PUT;
                            end
                            default:
                            begin
                                ph_next  = rsrd_pkg::PH_HDR0;
                                pl_next  = 2'd0;
                                col_next = 16'd0;
                                lw_next  = 16'd0;
                                row_next = 15'd0;
                                lit_next = 8'd0;
                                hdr_next = 24'd0;
                            end
                        endcase
                    end
                end
            end
            rsrd_pkg::ST_PUT:
            begin
                // one colour value a cycle into the line memory
                we = (col_reg < 16'(rsrd_pkg::MAX_WIDTH));
                left_next = left_reg - 8'd1;
                if (x1 >= {1'b0, lw_reg})
                begin
                    col_next = 16'd0;
                    lit_next = 8'd0;
                    pl_next  = pl_reg + 2'd1;
                    ph_next  = rsrd_pkg::PH_CODE;
                    st_next  = rsrd_pkg::ST_IDLE;
                end
                else
                begin
                    col_next = x1[15:0];
                    if (left_reg == 8'd1)
                    begin
                        if (litm_reg && lit_reg == 8'd0)
                        begin
                            ph_next = rsrd_pkg::PH_CODE;
                        end
                        st_next = rsrd_pkg::ST_IDLE;
                    end
                end
            end
            rsrd_pkg::ST_EXP:
            begin
                // hold while a pixel pair is due and the output is still full
                if (!(emit0 && ovalid_reg && !out_ch.ready))
                begin
                    if (le)
                    begin
                        row_next = row_reg + 15'd1;
                        ph_next  = rsrd_pkg::PH_HDR0;
                        pl_next  = 2'd0;
                        col_next = 16'd0;
                        lit_next = 8'd0;
                    end
                    else if (!more)
                    begin
                        col_next = xk[15:0];
                        if (litm_reg && lit_reg == 8'd0)
                        begin
                            ph_next = rsrd_pkg::PH_CODE;
                        end
                    end
                    else
                    begin
                        col_next = xk[15:0];
                    end
                    left_next = leftk;
                    more_next = more;
                    if (emit0)
                    begin
                        re        = 1'b1;
                        pcol_next = col_reg[AW-1:0];
                        has2_next = emit1;
                        last_next = !(more && xk < lim);
                        st_next   = rsrd_pkg::ST_CONV;
                    end
                    else
                    begin
                        st_next = more ? rsrd_pkg::ST_EXP : rsrd_pkg::ST_IDLE;
                    end
                end
            end
            rsrd_pkg::ST_CONV:
            begin
                oload   = 1'b1;
                st_next = (more_reg && !last_reg) ? rsrd_pkg::ST_EXP
                        : (more_reg ? rsrd_pkg::ST_EXP : rsrd_pkg::ST_IDLE);
            end
            default:
            begin
                st_next = rsrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (oload)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= rsrd_pkg::ST_IDLE;
            ph_reg     <= rsrd_pkg::PH_HDR0;
            pl_reg     <= 2'd0;
            col_reg    <= 16'd0;
            lw_reg     <= 16'd0;
            row_reg    <= 15'd0;
            lit_reg    <= 8'd0;
            hdr_reg    <= 24'd0;
            left_reg   <= 8'd0;
            litm_reg   <= 1'b0;
            more_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            ph_reg     <= ph_next;
            pl_reg     <= pl_next;
            col_reg    <= col_next;
            lw_reg     <= lw_next;
            row_reg    <= row_next;
            lit_reg    <= lit_next;
            hdr_reg    <= hdr_next;
            left_reg   <= left_next;
            litm_reg   <= litm_next;
            more_reg   <= more_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        orow_reg <= orow_next;
        pcol_reg <= pcol_next;
        has2_reg <= has2_next;
        last_reg <= last_next;
        if (oload)
        begin
            orow_out_reg <= orow_reg;
            ocol_out_reg <= 12'(pcol_reg);
            r1_reg <= cr1;
            g1_reg <= cg1;
            b1_reg <= cb1;
            r2_reg <= has2_reg ? cr2 : 32'd0;
            g2_reg <= has2_reg ? cg2 : 32'd0;
            b2_reg <= has2_reg ? cb2 : 32'd0;
            sv_reg <= has2_reg;
            lr_reg <= last_reg;
        end
    end

    // line memory: byte write of the current plane, two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            case (rsrd_pkg::plane_t'(pl_reg))
                rsrd_pkg::PL_RED:   mem_q[waddr][7:0]   <= wdata;
                rsrd_pkg::PL_GREEN: mem_q[waddr][15:8]  <= wdata;
                rsrd_pkg::PL_BLUE:  mem_q[waddr][23:16] <= wdata;
                default:            mem_q[waddr]        <= mem_q[waddr];
            endcase
        end
        if (re)
        begin
            rd0_reg <= mem_q[raddr0];
            rd1_reg <= mem_q[raddr1];
        end
    end

    rsrd_pix_cvt u_cvt_first (
        .mant  (rd0_reg),
        .expo  (exp_reg),
        .red   (cr1),
        .green (cg1),
        .blue  (cb1)
    );

    rsrd_pix_cvt u_cvt_second (
        .mant  (rd1_reg),
        .expo  (exp_reg),
        .red   (cr2),
        .green (cg2),
        .blue  (cb2)
    );

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.pixel_row    = orow_out_reg;
    assign out_ch.pixel_column = ocol_out_reg;
    assign out_ch.red_first    = r1_reg;
    assign out_ch.green_first  = g1_reg;
    assign out_ch.blue_first   = b1_reg;
    assign out_ch.red_second   = r2_reg;
    assign out_ch.green_second = g2_reg;
    assign out_ch.blue_second  = b2_reg;
    assign out_ch.second_valid = sv_reg;
    assign out_ch.last_of_run  = lr_reg;

endmodule

### hw/rtl/rsrd_checker.sv
`include "rgbe_scanline_rle_decoder_macros.svh"

module rsrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] pixel_column,
    input logic [31:0] red_second,
    input logic [31:0] green_second,
    input logic [31:0] blue_second,
    input logic        second_valid,
    input logic        pready
);

    // a held request stays valid
    `RSRD_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)
    // an absent second pixel reads as zero
    `RSRD_ASSERT_NOW(a_second_zero, out_valid && !second_valid,
        red_second == 32'd0 && green_second == 32'd0 && blue_second == 32'd0)
    // a pair never runs past the last column of the line memory
    `RSRD_ASSERT_NOW(a_pair_in_line, out_valid && second_valid, pixel_column != 12'hFFF)
    // the register port never inserts wait states
    `RSRD_ASSERT_NOW(a_no_wait, 1'b1, pready)

endmodule

bind rgbe_scanline_rle_decoder rsrd_checker u_rsrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .pixel_column (out_ch.pixel_column),
    .red_second   (out_ch.red_second),
    .green_second (out_ch.green_second),
    .blue_second  (out_ch.blue_second),
    .second_valid (out_ch.second_valid),
    .pready       (pready)
);

### bench/rgbe_pixel_checker.sv
`timescale 1ns / 100ps

module rgbe_pixel_checker
    import rsrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rsrd_in_if          in_ch,
    rsrd_out_if         out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pairs_due
);

    typedef struct {
        logic [14:0] row;
        logic [11:0] column;
        logic [31:0] red_a, green_a, blue_a;
        logic [31:0] red_b, green_b, blue_b;
        logic        second_ok;
        logic        last;
    } pixel_pair_t;

    pixel_pair_t pair_q[$];
    int unsigned exp_cols[$];

    logic [7:0]  red_line   [MAX_WIDTH];
    logic [7:0]  green_line [MAX_WIDTH];
    logic [7:0]  blue_line  [MAX_WIDTH];
    phase_t      phase;
    plane_t      plane;
    logic [15:0] col_cnt;
    logic [15:0] line_w;
    logic [14:0] row_cnt;
    logic [7:0]  lit_left;
    logic [23:0] hdr;
    logic [12:0] img_w;
    logic [14:0] img_h;

    // Exact IEEE single of m * 2^(e - 136); subnormal below the normal range.
    function automatic logic [31:0] to_ieee(logic [7:0] m, logic [7:0] e);
        int msb;
        int ex;
        logic [31:0] frac;
        if (e == 0 || m == 0)
            return 32'd0;
        msb = 7;
        while (!m[msb])
            msb--;
        ex = msb + int'(e) - 136;
        frac = 32'(m) << (23 - msb);
        if (ex >= -126)
            return {1'b0, 8'(ex + 127), frac[22:0]};
        return 32'(m) << (int'(e) + 13);
    endfunction

    function automatic void clear_rows();
        phase = PH_HDR0;
        plane = PL_RED;
        col_cnt = '0;
        line_w = '0;
        row_cnt = '0;
        lit_left = '0;
        hdr = '0;
    endfunction

    function automatic void row_done();
        row_cnt = row_cnt + 15'd1;
        phase = PH_HDR0;
        plane = PL_RED;
        col_cnt = '0;
        lit_left = '0;
    endfunction

    function automatic void store_value(logic [7:0] v);
        int unsigned lim;
        lim = (img_w < MAX_WIDTH) ? img_w : MAX_WIDTH;
        if (col_cnt < MAX_WIDTH) begin
            case (plane)
                PL_RED:   red_line[col_cnt]   = v;
                PL_GREEN: green_line[col_cnt] = v;
                PL_BLUE:  blue_line[col_cnt]  = v;
                default:  if (col_cnt < lim && exp_cols.size() < 128) exp_cols.push_back(col_cnt);
            endcase
        end
        col_cnt = col_cnt + 16'd1;
    endfunction

    // Close the plane, and the row after the exponent plane, at the line end.
    function automatic bit line_end();
        if (col_cnt < line_w)
            return 0;
        col_cnt = '0;
        lit_left = '0;
        if (plane == PL_EXP)
            row_done();
        else begin
            plane = plane_t'(plane + 2'd1);
            phase = PH_CODE;
        end
        return 1;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic soi);
        logic [14:0] row;
        pixel_pair_t pp;
        int n;
        exp_cols.delete();
        if (soi)
            clear_rows();
        if (row_cnt >= img_h)
            return;
        row = row_cnt;
        case (phase)
            PH_HDR0, PH_HDR1, PH_HDR2:
            begin
                hdr = {hdr[15:0], b};
                phase = phase_t'(phase + 3'd1);
            end
            PH_HDR3:
            begin
                if (hdr[23:8] == ROW_MARK) begin
                    line_w = {hdr[7:0], b};
                    plane = PL_RED;
                    col_cnt = '0;
                    lit_left = '0;
                    phase = PH_CODE;
                    if (line_w == 0)
                        row_done();
                end else
                    row_done();
                hdr = '0;
            end
            PH_CODE:
            begin
                if (b > RUN_BIAS) begin
                    lit_left = b - RUN_BIAS;
                    phase = PH_RUNVAL;
                end else if (b != 0) begin
                    lit_left = b;
                    phase = PH_LIT;
                end
            end
            PH_RUNVAL:
            begin
                phase = PH_CODE;
                while (lit_left > 0) begin
                    lit_left--;
                    store_value(b);
                    if (line_end())
                        break;
                end
            end
            PH_LIT:
            begin
                store_value(b);
                lit_left = lit_left - 8'd1;
                if (!line_end() && lit_left == 0)
                    phase = PH_CODE;
            end
            default: clear_rows();
        endcase
        n = 0;
        for (int i = 0; i < exp_cols.size() && n < 64; i += 2) begin
            pp.row = row;
            pp.column = exp_cols[i][11:0];
            pp.red_a = to_ieee(red_line[exp_cols[i]], b);
            pp.green_a = to_ieee(green_line[exp_cols[i]], b);
            pp.blue_a = to_ieee(blue_line[exp_cols[i]], b);
            pp.second_ok = (i + 1 < exp_cols.size());
            pp.red_b = pp.second_ok ? to_ieee(red_line[exp_cols[i+1]], b) : 32'd0;
            pp.green_b = pp.second_ok ? to_ieee(green_line[exp_cols[i+1]], b) : 32'd0;
            pp.blue_b = pp.second_ok ? to_ieee(blue_line[exp_cols[i+1]], b) : 32'd0;
            pp.last = 1'b0;
            pair_q.push_back(pp);
            n++;
        end
        if (n > 0)
            pair_q[$].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pixel_pair_t want;
        if (!rst_n) begin
            clear_rows();
            img_w = 13'(RESET_WIDTH);
            img_h = 15'(RESET_HEIGHT);
            pair_q.delete();
            errors = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pair_q.size() == 0) begin
                    $display("%0t: unexpected pixel pair, row %0d column %0d", $time,
                             out_ch.pixel_row, out_ch.pixel_column);
                    errors++;
                end else begin
                    want = pair_q.pop_front();
                    check_field("pixel_row", want.row, out_ch.pixel_row);
                    check_field("pixel_column", want.column, out_ch.pixel_column);
                    check_field("red_first", want.red_a, out_ch.red_first);
                    check_field("green_first", want.green_a, out_ch.green_first);
                    check_field("blue_first", want.blue_a, out_ch.blue_first);
                    check_field("red_second", want.red_b, out_ch.red_second);
                    check_field("green_second", want.green_b, out_ch.green_second);
                    check_field("blue_second", want.blue_b, out_ch.blue_second);
                    check_field("second_valid", want.second_ok, out_ch.second_valid);
                    check_field("last_of_run", want.last, out_ch.last_of_run);
                end
            end
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.data_byte, in_ch.start_of_image);
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[2]))
                    REG_WIDTH:  img_w = pwdata[12:0];
                    REG_HEIGHT: img_h = pwdata[14:0];
                endcase
            end
        end
        pairs_due = pair_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import rsrd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pairs_due;

    // Idle and stall odds in percent, changed per phase.
    int          src_idle;
    int          snk_stall;
    // Long receiver hold-off: raised by the stimulus, served by the receiver.
    bit          hold_req;
    int          hold_left;
    // Flag the next request as the first byte of an image.
    bit          soi_next;
    int          byte_count;

    rsrd_in_if  in_if ();
    rsrd_out_if out_if ();

    rgbe_scanline_rle_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if.sink),
        .out_ch  (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rgbe_pixel_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .errors    (errors),
        .pairs_due (pairs_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall at random, or hold off entirely while a hold-off runs.
    always @(negedge clk)
    begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (!rst_n)
            out_if.ready = 1'b0;
        else if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left--;
        end else
            out_if.ready = ($urandom_range(99) >= snk_stall);
    end

    // Offer one byte, idling at random first; return after it is accepted.
    task automatic push(input logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.data_byte = b;
        in_if.start_of_image = soi_next;
        soi_next = 1'b0;
        do
            @(posedge clk);
        while (!in_if.ready);
        @(negedge clk);
        byte_count++;
    endtask

    // Exponents favour zero, the subnormal range and the top end.
    function automatic logic [7:0] pick_value(bit is_exp);
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return is_exp ? 8'($urandom_range(1, 12)) : 8'd1;
            3: return is_exp ? 8'($urandom_range(120, 140)) : 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Code one plane as a random mix of runs, literals and null codes (runs only
    // with runs_only); some runs and literals overshoot the line end and get cut there.
    task automatic encode_plane(input int width, input bit is_exp, input bit runs_only);
        int left;
        int n;
        left = width;
        while (left > 0) begin
            if (runs_only) begin
                push(8'(RUN_BIAS + 127));
                push(pick_value(is_exp));
                left -= 127;
            end else begin
                case ($urandom_range(9))
                    0: push(8'd0);
                    1, 2, 3, 4, 5:
                    begin
                        n = ($urandom_range(3) == 0) ? $urandom_range(1, 127)
                                                     : $urandom_range(1, (left < 127) ? left : 127);
                        push(8'(RUN_BIAS + n));
                        push(pick_value(is_exp));
                        left -= n;
                    end
                    default:
                    begin
                        n = ($urandom_range(4) == 0) ? $urandom_range(1, 128)
                                                     : $urandom_range(1, 6);
                        push(8'(n));
                        repeat ((n < left) ? n : left)
                            push(pick_value(is_exp));
                        left -= n;
                    end
                endcase
            end
        end
    endtask

    task automatic good_row(input int width, input bit runs_only);
        push(8'd2);
        push(8'd2);
        push(8'(width >> 8));
        push(8'(width));
        if (width > 0)
            for (int p = 0; p < 4; p++)
                encode_plane(width, p == PL_EXP, runs_only);
    endtask

    // Header without the row mark: four bytes used up, no pixels.
    task automatic broken_row();
        logic [7:0] b0;
        b0 = 8'($urandom_range(255));
        push(b0);
        push((b0 == 8'd2) ? 8'($urandom_range(3, 255)) : 8'($urandom_range(255)));
        push(8'($urandom_range(255)));
        push(8'($urandom_range(255)));
    endtask

    task automatic random_image(input int max_w);
        soi_next = 1'b1;
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(19))
                0: good_row(0, 1'b0);
                1: broken_row();
                2:
                begin
                    // Noise, then restart the image.
                    repeat ($urandom_range(1, 6))
                        push(8'($urandom_range(255)));
                    soi_next = 1'b1;
                end
                default: good_row($urandom_range(1, max_w), 1'b0);
            endcase
        end
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Drain the decoder before touching its registers: an exponent byte with
    // no visible pixels can still be walking the line memory.
    task automatic set_image(input int w, input int h);
        in_if.valid = 1'b0;
        while (pairs_due != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
    endtask

    initial
    begin
        int cfg_w [4];
        int cfg_h [4];
        int idle_src [4];
        int idle_snk [4];
        int mark;
        cfg_w = '{1, 24, 4096, 13};
        cfg_h = '{3, 32767, 5, 1};
        idle_src = '{0, 48, 0, 36};
        idle_snk = '{0, 0, 48, 36};
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.start_of_image = 1'b0;
        out_if.ready = 1'b0;
        src_idle = 0;
        snk_stall = 0;
        hold_req = 1'b0;
        hold_left = 0;
        soi_next = 1'b0;
        byte_count = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset image size.
        soi_next = 1'b1;
        push(8'd2); push(8'd2); push(8'd0); push(8'd3);
        push(8'd3); push(8'd0); push(8'd255); push(8'd128);   // red literals
        push(8'd0);                                          // null code
        push(8'(RUN_BIAS + 5)); push(8'd1);                  // green run past line end
        push(8'd3); push(8'd7); push(8'd255); push(8'd9);    // blue literals
        push(8'd3); push(8'd0); push(8'd255); push(8'd1);    // exponents: zero, top, subnormal
        push(8'd2); push(8'd2); push(8'd0); push(8'd0);      // zero scan width
        broken_row();
        good_row(2, 1'b0);

        // Random phases with changing image size and idling.
        for (int ph = 0; ph < 4; ph++) begin
            set_image(cfg_w[ph], cfg_h[ph]);
            src_idle = idle_src[ph];
            snk_stall = idle_snk[ph];
            if (ph == 1)
                hold_req = 1'b1;
            mark = byte_count;
            while (byte_count - mark < 40)
                random_image(16);
        end

        in_if.valid = 1'b0;
        while (pairs_due != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
